[rtl/assert_macros.svh]
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ADLL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define ADLL_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/adll_pkg.sv]
package adll_pkg;

	localparam int KIND_W     = 3;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 120;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [KIND_W-1:0] KIND_INS_AFTER  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_BEFORE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NTH        = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX  = 2'd2;
	localparam logic [1:0] ST_NOT_LINEAR = 2'd3;

	typedef enum logic [2:0] {
		OP_INS_AFTER,
		OP_INS_BEFORE,
		OP_ERASE,
		OP_READ,
		OP_NTH,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_COMMIT
	} state_t;

	// Request word as it arrives on the input stream, lowest field last.
	typedef struct packed {
		logic [7:0]  position;
		logic [63:0] data_value;
		logic [7:0]  node_index;
	} in_word_t;

	// Classified request held in the queue between front and back.
	typedef struct packed {
		op_t         op;
		logic        in_range;
		logic [7:0]  node_index;
		logic [63:0] data_value;
		logic [7:0]  position;
	} entry_t;

	// Result word on the output stream, lowest field last.
	typedef struct packed {
		logic [4:0]  pad;
		logic [7:0]  last_index;
		logic [7:0]  first_index;
		logic        linear_flag;
		logic [7:0]  element_count;
		logic [7:0]  prev_index;
		logic [7:0]  next_index;
		logic [63:0] node_value;
		logic [7:0]  result_index;
		logic [1:0]  status;
	} out_word_t;

endpackage

[rtl/adll_front.sv]
module adll_front #(
	parameter int CAPACITY = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [adll_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [adll_pkg::KIND_W-1:0]     s_tuser,
	input  logic                            clearing,
	output logic                            q_valid,
	input  logic                            q_pop,
	output adll_pkg::entry_t                q_entry
);
	import adll_pkg::*;

	in_word_t         in_w;
	entry_t           cls;
	entry_t           buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic             push;

	assign in_w = s_tdata;

	always_comb begin
		cls.node_index = in_w.node_index;
		cls.data_value = in_w.data_value;
		cls.position   = in_w.position;
		cls.in_range   = 32'(in_w.node_index) < CAPACITY;
		unique case (s_tuser)
			KIND_INS_AFTER:  cls.op = OP_INS_AFTER;
			KIND_INS_BEFORE: cls.op = OP_INS_BEFORE;
			KIND_ERASE:      cls.op = OP_ERASE;
			KIND_READ:       cls.op = OP_READ;
			KIND_NTH:        cls.op = OP_NTH;
			default:         cls.op = OP_NOP;
		endcase
	end

	// No transaction is taken while the link memories are being initialized.
	assign s_tready = !clearing && (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = cnt_q != '0;
	assign q_entry  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/adll_back.sv]
module adll_back #(
	parameter int CAPACITY   = 256,
	parameter int VALUE_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  adll_pkg::entry_t    q_entry,
	output logic                clearing,
	output logic                out_valid,
	input  logic                out_ready,
	output adll_pkg::out_word_t out_word
);
	import adll_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] LAST_NODE = IW'(CAPACITY - 1);

	state_t state_q, state_d;

	logic [IW-1:0] clr_q, clr_d;
	logic [IW-1:0] free_head_q, free_head_d;
	logic [IW-1:0] count_q, count_d;
	logic [IW-1:0] head_q, head_d;
	logic [IW-1:0] tail_q, tail_d;
	logic          contig_q, contig_d;
	logic [IW-1:0] before_q, after_q;
	entry_t        cur_q;
	logic          out_valid_q;
	out_word_t     out_q, out_d;
	logic          out_load;

	// Link, free-mark and value memories: one write and one read port each.
	logic [IW-1:0]         nx_mem [CAPACITY];
	logic [IW-1:0]         pr_mem [CAPACITY];
	logic                  fr_mem [CAPACITY];
	logic [VALUE_BITS-1:0] vl_mem [CAPACITY];

	logic                  nx_we, pr_we, fr_we, vl_we;
	logic [IW-1:0]         nx_wa, pr_wa, fr_wa, vl_wa;
	logic [IW-1:0]         nx_wd, pr_wd;
	logic                  fr_wd;
	logic [VALUE_BITS-1:0] vl_wd;
	logic [IW-1:0]         nx_ra, rd_a;
	logic [IW-1:0]         nx_rd_q, pr_rd_q;
	logic                  fr_rd_q;
	logic [VALUE_BITS-1:0] vl_rd_q;

	logic [IW-1:0] q_idx, cur_idx;
	logic          pop;
	logic          is_ins, bad_ins, full, bad_node, ins_go, er_go, ins_contig;
	logic [IW-1:0] ins_before, ins_after;

	always_ff @(posedge clk) begin
		if (nx_we) begin
			nx_mem[nx_wa] <= nx_wd;
		end
		nx_rd_q <= nx_mem[nx_ra];
	end

	always_ff @(posedge clk) begin
		if (pr_we) begin
			pr_mem[pr_wa] <= pr_wd;
		end
		pr_rd_q <= pr_mem[rd_a];
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			fr_mem[fr_wa] <= fr_wd;
		end
		fr_rd_q <= fr_mem[rd_a];
	end

	always_ff @(posedge clk) begin
		if (vl_we) begin
			vl_mem[vl_wa] <= vl_wd;
		end
		vl_rd_q <= vl_mem[rd_a];
	end

	assign q_idx    = IW'(q_entry.node_index);
	assign cur_idx  = IW'(cur_q.node_index);
	assign clearing = state_q == S_CLEAR;
	// A request starts only when the result register is free by the time it finishes.
	assign pop      = (state_q == S_IDLE) && q_valid && (!out_valid_q || out_ready);
	assign q_pop    = pop;
	assign rd_a     = q_idx;

	always_comb begin
		is_ins     = (cur_q.op == OP_INS_AFTER) || (cur_q.op == OP_INS_BEFORE);
		bad_ins    = !cur_q.in_range || ((cur_idx != '0) && fr_rd_q);
		full       = free_head_q == '0;
		bad_node   = !cur_q.in_range || (cur_idx == '0) || fr_rd_q;
		ins_before = (cur_q.op == OP_INS_AFTER) ? cur_idx : pr_rd_q;
		ins_after  = (cur_q.op == OP_INS_AFTER) ? nx_rd_q : cur_idx;
		ins_go     = is_ins && !bad_ins && !full;
		er_go      = (cur_q.op == OP_ERASE) && !bad_node;
		// A new node directly after its predecessor, and before its successor
		// or the sentinel, keeps the layout contiguous.
		ins_contig = (({1'b0, ins_before} + 1'b1) == {1'b0, free_head_q})
			&& ((({1'b0, free_head_q} + 1'b1) == {1'b0, ins_after})
			|| (ins_after == '0));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_NODE) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (pop) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = (ins_go || er_go) ? S_COMMIT : S_IDLE;
			end
			S_COMMIT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pr_we = 1'b0; pr_wa = '0; pr_wd = '0;
		fr_we = 1'b0; fr_wa = '0; fr_wd = 1'b0;
		vl_we = 1'b0; vl_wa = '0; vl_wd = '0;
		nx_ra       = q_idx;
		clr_d       = clr_q;
		free_head_d = free_head_q;
		count_d     = count_q;
		head_d      = head_q;
		tail_d      = tail_q;
		contig_d    = contig_q;
		out_load    = 1'b0;
		out_d       = '0;
		unique case (state_q)
			S_CLEAR: begin
				nx_we = 1'b1;
				nx_wa = clr_q;
				nx_wd = ((clr_q == '0) || (clr_q == LAST_NODE)) ? '0 : clr_q + 1'b1;
				pr_we = 1'b1;
				pr_wa = clr_q;
				pr_wd = '0;
				fr_we = 1'b1;
				fr_wa = clr_q;
				fr_wd = clr_q != '0;
				clr_d = clr_q + 1'b1;
			end
			S_IDLE: begin
			end
			S_EVAL: begin
				// Fetch the successor of the free-chain head for a following commit.
				nx_ra = free_head_q;
				if (ins_go) begin
					nx_we = 1'b1;
					nx_wa = ins_before;
					nx_wd = free_head_q;
					pr_we = 1'b1;
					pr_wa = ins_after;
					pr_wd = free_head_q;
					if (ins_before == '0) begin
						head_d = free_head_q;
					end
					if (ins_after == '0) begin
						tail_d = free_head_q;
					end
					contig_d = contig_q && ins_contig;
				end else if (er_go) begin
					nx_we = 1'b1;
					nx_wa = pr_rd_q;
					nx_wd = nx_rd_q;
					pr_we = 1'b1;
					pr_wa = nx_rd_q;
					pr_wd = pr_rd_q;
					if (pr_rd_q == '0) begin
						head_d = nx_rd_q;
					end
					if (nx_rd_q == '0) begin
						tail_d = pr_rd_q;
					end
					contig_d = contig_q && ((nx_rd_q == '0) || (pr_rd_q == '0));
				end else begin
					out_load = 1'b1;
					case (cur_q.op) inside
						OP_INS_AFTER, OP_INS_BEFORE: begin
							out_d.status = bad_ins ? ST_BAD_INDEX : ST_FULL;
						end
						OP_ERASE: begin
							out_d.status = ST_BAD_INDEX;
						end
						OP_READ: begin
							if (bad_node) begin
								out_d.status = ST_BAD_INDEX;
							end else begin
								out_d.status       = ST_OK;
								out_d.result_index = 8'(cur_idx);
								out_d.node_value   = 64'(vl_rd_q);
								out_d.next_index   = 8'(nx_rd_q);
								out_d.prev_index   = 8'(pr_rd_q);
							end
						end
						OP_NTH: begin
							if (!contig_q || (32'(cur_q.position) >= 32'(count_q))) begin
								out_d.status = ST_NOT_LINEAR;
							end else begin
								out_d.status       = ST_OK;
								out_d.result_index = 8'(head_q) + cur_q.position;
							end
						end
						default: begin
							out_d.status = ST_OK;
						end
					endcase
				end
			end
			S_COMMIT: begin
				out_load     = 1'b1;
				out_d.status = ST_OK;
				if (is_ins) begin
					nx_we = 1'b1;
					nx_wa = free_head_q;
					nx_wd = after_q;
					pr_we = 1'b1;
					pr_wa = free_head_q;
					pr_wd = before_q;
					fr_we = 1'b1;
					fr_wa = free_head_q;
					fr_wd = 1'b0;
					vl_we = 1'b1;
					vl_wa = free_head_q;
					vl_wd = VALUE_BITS'(cur_q.data_value);
					free_head_d        = nx_rd_q;
					count_d            = count_q + 1'b1;
					out_d.result_index = 8'(free_head_q);
				end else begin
					nx_we = 1'b1;
					nx_wa = cur_idx;
					nx_wd = free_head_q;
					pr_we = 1'b1;
					pr_wa = cur_idx;
					pr_wd = '0;
					fr_we = 1'b1;
					fr_wa = cur_idx;
					fr_wd = 1'b1;
					free_head_d = cur_idx;
					count_d     = (count_q != '0) ? count_q - 1'b1 : count_q;
				end
			end
			default: begin
			end
		endcase
		out_d.element_count = 8'(count_d);
		out_d.linear_flag   = contig_d;
		out_d.first_index   = 8'(head_d);
		out_d.last_index    = 8'(tail_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			free_head_q <= IW'(1);
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			contig_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			free_head_q <= free_head_d;
			count_q     <= count_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			contig_q    <= contig_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_entry;
		end
		if (state_q == S_EVAL) begin
			before_q <= ins_before;
			after_q  <= ins_after;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

[rtl/array_doubly_linked_list_core.sv]
// Insert and erase pass through the back sequencer's fetch, evaluate and commit states;
// read, nth, unused kinds and failed requests pass through fetch and evaluate only.
// The back sequencer takes one request at a time over the link memories, while the
// front queue can accept further requests meanwhile.
// Reset is asynchronous; after it, a pass over every node initializes the link and
// free-mark memories, and s_tready stays low until that pass is done.
module array_doubly_linked_list_core #(
	parameter int CAPACITY   = 256,
	parameter int VALUE_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// node_index[7:0], data_value[71:8], position[79:72]
	input  logic [adll_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind[2:0]
	input  logic [adll_pkg::KIND_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[1:0], result_index[9:2], node_value[73:10], next_index[81:74],
	// prev_index[89:82], element_count[97:90], linear_flag[98], first_index[106:99],
	// last_index[114:107], zero fill[119:115]
	output logic [adll_pkg::OUT_DATA_W-1:0] m_tdata
);
	import adll_pkg::*;

	logic      clearing;
	logic      q_valid;
	logic      q_pop;
	entry_t    q_entry;
	out_word_t out_word;

	adll_front #(
		.CAPACITY(CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_entry  (q_entry)
	);

	adll_back #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_entry),
		.clearing  (clearing),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word)
	);

	assign m_tdata = out_word;

endmodule

[rtl/adll_checker.sv]
`include "assert_macros.svh"

module adll_checker #(
	parameter int CAPACITY = 256
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [adll_pkg::OUT_DATA_W-1:0] m_tdata
);
	import adll_pkg::*;

	out_word_t w;

	assign w = m_tdata;

	`ADLL_ASSERT_RST(a_reset_quiet, !arst_n |-> (!s_tready && !m_tvalid), "ports active in reset")
	`ADLL_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")
	`ADLL_ASSERT(a_full_count, (m_tvalid && (w.status == ST_FULL)) |-> (w.element_count == 8'(CAPACITY - 1)), "full reported with free nodes")
	`ADLL_ASSERT(a_fail_clean, (m_tvalid && (w.status != ST_OK)) |-> ((w.result_index == 8'd0) && (w.node_value == 64'd0)), "failed request returned data")

endmodule

bind array_doubly_linked_list_core adll_checker #(
	.CAPACITY(CAPACITY)
) u_adll_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[verif/tb_array_doubly_linked_list_core.sv]
`timescale 1ns / 100ps

module tb_array_doubly_linked_list_core;
	import adll_pkg::*;

	localparam int NODES          = 256;
	localparam int RANDOM_ITEMS   = 750;
	localparam int LINEAR_ITEMS   = 380;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;

	localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

	// Mirror of the node store; predicts one result word per request.
	class list_scoreboard;
		bit [63:0]   node_word[NODES];
		bit [7:0]    succ_link[NODES];
		bit [7:0]    pred_link[NODES];
		bit          on_free_chain[NODES];
		bit [7:0]    free_head;
		int unsigned elements;
		bit          linear;
		out_word_t   expected_q[$];
		int          errors;
		int          checked;
		int          requests;
		int          peak;
		int          stat_count[4];

		function new();
			for (int i = 0; i < NODES; i++) begin
				node_word[i] = '0;
				succ_link[i] = (i == 0) ? 8'd0 : 8'((i + 1) % NODES);
				pred_link[i] = 8'd0;
				on_free_chain[i] = (i != 0);
			end
			free_head = 8'd1;
			elements = 0;
			linear = 1'b1;
			errors = 0;
			checked = 0;
			requests = 0;
			peak = 0;
			for (int s = 0; s < 4; s++)
				stat_count[s] = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Random node currently in the list, or the sentinel when the list is empty.
		function bit [7:0] pick_node();
			bit [7:0] idx;
			if (elements == 0)
				return 8'd0;
			do
				idx = 8'($urandom_range(1, NODES - 1));
			while (on_free_chain[idx]);
			return idx;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [7:0] idx,
				logic [63:0] val, logic [7:0] pos);
			out_word_t r;
			int added;
			int pn;
			int sn;
			r = '0;
			requests++;
			case (kind) inside
				KIND_INS_AFTER, KIND_INS_BEFORE: begin
					if (idx != 0 && on_free_chain[idx]) begin
						r.status = ST_BAD_INDEX;
					end else if (free_head == 0) begin
						r.status = ST_FULL;
					end else begin
						added = free_head;
						if (kind == KIND_INS_AFTER) begin
							pn = idx;
							sn = succ_link[idx];
						end else begin
							pn = pred_link[idx];
							sn = idx;
						end
						// Appending at the tail in index order keeps the layout contiguous.
						if (!(pn + 1 == added && (added + 1 == sn || sn == 0)))
							linear = 1'b0;
						free_head = succ_link[added];
						node_word[added] = val;
						succ_link[added] = 8'(sn);
						pred_link[added] = 8'(pn);
						on_free_chain[added] = 1'b0;
						succ_link[pn] = 8'(added);
						pred_link[sn] = 8'(added);
						elements++;
						r.result_index = 8'(added);
					end
				end
				KIND_ERASE: begin
					if (idx == 0 || on_free_chain[idx]) begin
						r.status = ST_BAD_INDEX;
					end else begin
						sn = succ_link[idx];
						pn = pred_link[idx];
						succ_link[pn] = 8'(sn);
						pred_link[sn] = 8'(pn);
						node_word[idx] = '0;
						succ_link[idx] = free_head;
						pred_link[idx] = 8'd0;
						on_free_chain[idx] = 1'b1;
						free_head = idx;
						if (!(sn == 0 || pn == 0))
							linear = 1'b0;
						if (elements > 0)
							elements--;
					end
				end
				KIND_READ: begin
					if (idx == 0 || on_free_chain[idx]) begin
						r.status = ST_BAD_INDEX;
					end else begin
						r.result_index = idx;
						r.node_value = node_word[idx];
						r.next_index = succ_link[idx];
						r.prev_index = pred_link[idx];
					end
				end
				KIND_NTH: begin
					if (!linear || pos >= elements)
						r.status = ST_NOT_LINEAR;
					else
						r.result_index = 8'(succ_link[0] + pos);
				end
				default: ;
			endcase
			r.element_count = 8'(elements);
			r.linear_flag = linear;
			r.first_index = succ_link[0];
			r.last_index = pred_link[0];
			if (elements > peak)
				peak = elements;
			stat_count[r.status]++;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			out_word_t act;
			out_word_t exp_w;
			act = data;
			if (expected_q.size() == 0) begin
				$error("result transaction with no request outstanding: %h", data);
				errors++;
				return;
			end
			exp_w = expected_q[0];
			expected_q.delete(0);
			checked++;
			compare_field("status", exp_w.status, act.status);
			compare_field("result_index", exp_w.result_index, act.result_index);
			compare_field("node_value", exp_w.node_value, act.node_value);
			compare_field("next_index", exp_w.next_index, act.next_index);
			compare_field("prev_index", exp_w.prev_index, act.prev_index);
			compare_field("element_count", exp_w.element_count, act.element_count);
			compare_field("linear_flag", exp_w.linear_flag, act.linear_flag);
			compare_field("first_index", exp_w.first_index, act.first_index);
			compare_field("last_index", exp_w.last_index, act.last_index);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [KIND_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	list_scoreboard sb = new();

	int burst_left = 0;
	int idle_cycles = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_hold = 0;

	array_doubly_linked_list_core #(
		.CAPACITY(NODES),
		.VALUE_BITS(64)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] rand_word();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return 64'd0;
		if (pick == 1)
			return '1;
		return {$urandom(), $urandom()};
	endfunction

	// Called right after a rising edge; returns right after the accepting edge.
	task automatic send_request(logic [KIND_W-1:0] kind, logic [7:0] idx,
			logic [63:0] val, logic [7:0] pos);
		in_word_t w;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		w.position = pos;
		w.data_value = val;
		w.node_index = idx;
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= kind;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(kind, idx, val, pos);
	endtask

	task automatic send_noise();
		send_request(KIND_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
			rand_word(), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_nth_near_end();
		int top;
		top = (sb.elements + 1 > 255) ? 255 : sb.elements + 1;
		send_request(KIND_NTH, 8'($urandom_range(0, 255)), rand_word(),
			8'($urandom_range(0, top)));
	endtask

	task automatic run_directed();
		// Empty list: sentinel, free nodes and nth all refuse.
		send_request(KIND_READ, 8'd0, '1, 8'd0);
		send_request(KIND_ERASE, 8'd0, 64'd0, 8'd0);
		send_request(KIND_READ, 8'd5, 64'd0, 8'd0);
		send_request(KIND_NTH, 8'd0, 64'd0, 8'd0);
		send_request(KIND_INS_BEFORE, 8'd5, rand_word(), 8'd0);
		// Build nodes 1, 2, 3 in order so the layout stays contiguous.
		send_request(KIND_INS_AFTER, 8'd0, '1, 8'd0);
		send_request(KIND_INS_BEFORE, 8'd0, 64'd0, 8'd0);
		send_request(KIND_INS_AFTER, 8'd2, {$urandom(), $urandom()}, 8'd0);
		send_request(KIND_NTH, 8'd0, 64'd0, 8'd0);
		send_request(KIND_NTH, 8'd0, 64'd0, 8'd2);
		send_request(KIND_NTH, 8'd0, 64'd0, 8'd3);
		send_request(KIND_NTH, 8'd255, '1, 8'd255);
		send_request(KIND_READ, 8'd1, 64'd0, 8'd0);
		send_request(KIND_READ, 8'd2, 64'd0, 8'd0);
		send_request(KIND_UNUSED_FIRST, 8'd255, '1, 8'd255);
		send_request(KIND_UNUSED_FIRST + 3'd1, 8'd1, 64'd0, 8'd0);
		send_request(KIND_UNUSED_LAST, 8'd255, '1, 8'd255);
		// Erasing the tail keeps the layout; the erased node then reads as bad.
		send_request(KIND_ERASE, 8'd3, 64'd0, 8'd0);
		send_request(KIND_READ, 8'd3, 64'd0, 8'd0);
		send_request(KIND_ERASE, 8'd3, 64'd0, 8'd0);
		send_request(KIND_INS_AFTER, 8'd255, rand_word(), 8'd0);
		send_request(KIND_INS_BEFORE, 8'd0, rand_word(), 8'd0);
		send_request(KIND_NTH, 8'd0, 64'd0, 8'd2);
	endtask

	task automatic run_random();
		int roll;
		int mode_left;
		bit shrinking;
		logic [KIND_W-1:0] ins_kind;
		mode_left = 0;
		shrinking = 1'b0;
		// Tail appends first, so the list fills to capacity while nth stays valid.
		for (int n = 0; n < LINEAR_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 78) begin
				if ($urandom_range(0, 1))
					send_request(KIND_INS_BEFORE, 8'd0, rand_word(),
						8'($urandom_range(0, 255)));
				else
					send_request(KIND_INS_AFTER, sb.pred_link[0], rand_word(),
						8'($urandom_range(0, 255)));
			end else if (roll < 80) begin
				send_request(KIND_ERASE, sb.pred_link[0], rand_word(), 8'd0);
			end else if (roll < 90) begin
				send_nth_near_end();
			end else if (roll < 96) begin
				send_request(KIND_READ, sb.pick_node(), rand_word(),
					8'($urandom_range(0, 255)));
			end else begin
				send_noise();
			end
		end
		// Then alternating shrink and grow stretches at random positions.
		for (int n = LINEAR_ITEMS; n < RANDOM_ITEMS; n++) begin
			if (mode_left == 0) begin
				shrinking = !shrinking;
				mode_left = $urandom_range(40, 120);
			end
			mode_left--;
			roll = $urandom_range(0, 99);
			ins_kind = $urandom_range(0, 1) ? KIND_INS_AFTER : KIND_INS_BEFORE;
			if (shrinking) begin
				if (roll < 70)
					send_request(KIND_ERASE, sb.pick_node(), rand_word(), 8'd0);
				else if (roll < 80)
					send_request(ins_kind, sb.pick_node(), rand_word(), 8'd0);
				else if (roll < 87)
					send_request(KIND_READ, sb.pick_node(), rand_word(), 8'd0);
				else if (roll < 92)
					send_nth_near_end();
				else
					send_noise();
			end else begin
				if (roll < 15)
					send_request(ins_kind, 8'd0, rand_word(), 8'd0);
				else if (roll < 65)
					send_request(ins_kind, sb.pick_node(), rand_word(), 8'd0);
				else if (roll < 75)
					send_request(KIND_ERASE, sb.pick_node(), rand_word(), 8'd0);
				else if (roll < 85)
					send_request(KIND_READ, sb.pick_node(), rand_word(), 8'd0);
				else if (roll < 90)
					send_nth_near_end();
				else
					send_noise();
			end
		end
	endtask

	// Result side: check every accepted transaction, then pick the next ready value.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(50, 200);
		end
		rx_mode_left--;
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				default: begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 3) == 0)
						rx_hold = $urandom_range(1, 10);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("requests %0d, results checked %0d, peak occupancy %0d nodes",
			sb.requests, sb.checked, sb.peak);
		$display("status mix: ok %0d, full %0d, bad index %0d, nth refused %0d",
			sb.stat_count[ST_OK], sb.stat_count[ST_FULL],
			sb.stat_count[ST_BAD_INDEX], sb.stat_count[ST_NOT_LINEAR]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/adll_pkg.sv
rtl/adll_front.sv
rtl/adll_back.sv
rtl/array_doubly_linked_list_core.sv
rtl/adll_checker.sv
verif/tb_array_doubly_linked_list_core.sv
